// ===== rtl/crmu_pkg.sv =====
// ----------------------------------------------------------------------------
// crmu_pkg
// Shared types and constants of the cartridge ROM mapper with unlock.
// ----------------------------------------------------------------------------
package crmu_pkg;

    localparam int ROM_ADDR_W  = 22;
    localparam int BUS_ADDR_W  = 16;
    localparam int DATA_W      = 8;
    localparam int CMD_W       = 2;
    localparam int LOCK_W      = 2;
    localparam int CNT_W       = 6;
    localparam int PAD_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 22;
    localparam int BANK_SHIFT  = 14;

    // bus access commands
    localparam logic [CMD_W-1:0] CMD_ROM_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MAP_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MEM_WRITE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART   = 2'd3;

    // lock modes
    localparam logic [LOCK_W-1:0] LOCK_FIRST  = 2'd0;
    localparam logic [LOCK_W-1:0] LOCK_SECOND = 2'd1;
    localparam logic [LOCK_W-1:0] LOCK_OPEN   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_ADDR_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_CONFIG    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_LOCKED   = 2'd2;

    localparam logic [CNT_W-1:0]      UNLOCK_LIMIT     = 6'h30;
    localparam logic [ROM_ADDR_W-1:0] ROM_MASK_RESET   = 22'h3F_FFFF;
    localparam logic [2:0]            WRAM_REGION      = 3'b110;   // 0xC000-0xDFFF
    localparam logic [7:0]            HEADER_PAGE      = 8'h01;

    // mapper write decode on bus address bits 15:13
    localparam logic [2:0] SEL_OUTER_BANK = 3'd0;
    localparam logic [2:0] SEL_INNER_BANK = 3'd1;
    localparam logic [2:0] SEL_OUTER_MASK = 3'd2;

    typedef struct packed {
        logic [DATA_W-1:0] outer_bank;
        logic [DATA_W-1:0] outer_mask;
        logic [DATA_W-1:0] inner_bank;
        logic              force_a7;   // read sees second locked mode
    } t_map_view;

endpackage

// ===== rtl/crmu_state.sv =====
// ----------------------------------------------------------------------------
// crmu_state
// Mapper bank registers, lock mode and unlock counter; updated once per word.
// ----------------------------------------------------------------------------
module crmu_state
    import crmu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [BUS_ADDR_W-1:0] i_bus_address,
    input  logic [DATA_W-1:0]     i_write_data,
    input  logic                  i_boot_locked,
    output t_map_view             o_view
);

    logic [DATA_W-1:0] r_outer_bank, n_outer_bank;
    logic [DATA_W-1:0] r_outer_mask, n_outer_mask;
    logic [DATA_W-1:0] r_inner_bank, n_inner_bank;
    logic [LOCK_W-1:0] r_lock_mode,  n_lock_mode;
    logic [CNT_W-1:0]  r_unlock_cnt, n_unlock_cnt;

    logic       regs_open;
    logic [2:0] sel;
    logic       low_read;

    assign regs_open = (r_inner_bank[5:4] == 2'b11);
    assign sel       = i_bus_address[15:13];
    assign low_read  = (i_cmd == CMD_ROM_READ) && !i_bus_address[15];

    always_comb begin
        n_outer_bank = r_outer_bank;
        n_outer_mask = r_outer_mask;
        n_inner_bank = r_inner_bank;
        n_lock_mode  = r_lock_mode;
        n_unlock_cnt = r_unlock_cnt;
        unique case (i_cmd)
            CMD_RESTART: begin
                n_outer_bank = '0;
                n_outer_mask = '0;
                n_inner_bank = DATA_W'(1);
                n_lock_mode  = i_boot_locked ? LOCK_FIRST : LOCK_OPEN;
                n_unlock_cnt = '0;
            end
            CMD_MAP_WRITE, CMD_MEM_WRITE: begin
                if (i_cmd == CMD_MAP_WRITE) begin
                    if (sel == SEL_OUTER_BANK && regs_open) begin
                        n_outer_bank = i_write_data;
                    end else if (sel == SEL_INNER_BANK) begin
                        n_inner_bank = (i_write_data == '0) ? DATA_W'(1) : i_write_data;
                    end else if (sel == SEL_OUTER_MASK && regs_open) begin
                        n_outer_mask = i_write_data;
                    end
                end
                // work RAM write in first locked mode moves on to the second
                if (r_lock_mode == LOCK_FIRST && sel == WRAM_REGION) begin
                    n_lock_mode  = LOCK_SECOND;
                    n_unlock_cnt = '0;
                end
            end
            default: begin
                if (low_read) begin
                    if (r_unlock_cnt == UNLOCK_LIMIT && r_lock_mode == LOCK_FIRST) begin
                        n_lock_mode  = LOCK_SECOND;
                        n_unlock_cnt = CNT_W'(1);
                    end else begin
                        if (r_unlock_cnt == UNLOCK_LIMIT && r_lock_mode == LOCK_SECOND) begin
                            n_lock_mode = LOCK_OPEN;
                        end
                        if (r_unlock_cnt != UNLOCK_LIMIT) begin
                            n_unlock_cnt = r_unlock_cnt + CNT_W'(1);
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer_bank <= '0;
            r_outer_mask <= '0;
            r_inner_bank <= DATA_W'(1);
            r_lock_mode  <= LOCK_OPEN;
            r_unlock_cnt <= '0;
        end else if (i_step) begin
            r_outer_bank <= n_outer_bank;
            r_outer_mask <= n_outer_mask;
            r_inner_bank <= n_inner_bank;
            r_lock_mode  <= n_lock_mode;
            r_unlock_cnt <= n_unlock_cnt;
        end
    end

    always_comb begin
        o_view.outer_bank = r_outer_bank;
        o_view.outer_mask = r_outer_mask;
        o_view.inner_bank = r_inner_bank;
        o_view.force_a7   = (n_lock_mode == LOCK_SECOND);
    end

endmodule

// ===== rtl/crmu_addr.sv =====
// ----------------------------------------------------------------------------
// crmu_addr
// Builds the physical ROM address and open-bus flag for one ROM read.
// ----------------------------------------------------------------------------
module crmu_addr
    import crmu_pkg::*;
(
    input  logic [BUS_ADDR_W-1:0] i_bus_address,
    input  t_map_view             i_view,
    input  logic [ROM_ADDR_W-1:0] i_rom_addr_mask,
    input  logic [PAD_W-1:0]      i_pad_config,
    output logic [ROM_ADDR_W-1:0] o_rom_address,
    output logic                  o_open_bus
);

    logic [BUS_ADDR_W-1:0] a_lock;
    logic [BUS_ADDR_W-1:0] a_scr;
    logic [DATA_W-1:0]     fixed;
    logic [DATA_W-1:0]     bank;
    logic [ROM_ADDR_W-1:0] base;

    always_comb begin
        a_lock = i_bus_address;
        if (i_view.force_a7) begin
            a_lock[7] = 1'b1;
        end
        a_scr = a_lock;
        // header lines: swap bit pairs 0/6 and 1/4
        if (a_lock[15:8] == HEADER_PAGE) begin
            a_scr[0] = a_lock[6];
            a_scr[1] = a_lock[4];
            a_scr[4] = a_lock[1];
            a_scr[6] = a_lock[0];
        end
    end

    assign fixed = i_view.outer_bank & i_view.outer_mask;
    assign bank  = a_scr[14] ? (fixed | (i_view.inner_bank & ~i_view.outer_mask)) : fixed;
    assign base  = {bank, {BANK_SHIFT{1'b0}}} & i_rom_addr_mask;

    assign o_rom_address = base + ROM_ADDR_W'(a_scr[BANK_SHIFT-1:0]);
    assign o_open_bus    = (i_pad_config[0] && fixed[6]) || (i_pad_config[1] && fixed[5]);

endmodule

// ===== rtl/cartridge_rom_mapper_with_unlock.sv =====
// ----------------------------------------------------------------------------
// cartridge_rom_mapper_with_unlock
// ROM mapper with outer/inner banking, header scrambling and an unlock lock.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one bus access per word:
//   cmd, bus address and write data. Output channel (o_out_valid /
//   i_out_ready) carries the physical ROM address and open-bus flag, one
//   word for each ROM read below 0x8000; writes, restarts and reads at or
//   above 0x8000 give no output word.
//   An accepted word is held in the input register, and its result then
//   lands in the output register, which drives o_out_valid.
//   One word is taken every cycle while the receiver does not stall; the
//   mapper state update between the two registers sets that rate.
//   If the receiver stalls, a word with a result in the input register waits and
//   o_in_ready drops only once both registers are occupied.
//   Synchronous reset clears the mapper state (unlocked mode, inner bank 1),
//   sets the size mask to all ones, pads and boot lock to zero, and empties
//   both registers. Configuration writes via i_cfg_wr_en take effect on the
//   next cycle and belong to idle periods only.
// ----------------------------------------------------------------------------
module cartridge_rom_mapper_with_unlock
    import crmu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [BUS_ADDR_W-1:0] i_bus_address,
    input  logic [DATA_W-1:0]     i_write_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [ROM_ADDR_W-1:0] o_rom_address,
    output logic                  o_open_bus
);

    logic [ROM_ADDR_W-1:0] r_rom_addr_mask;
    logic [PAD_W-1:0]      r_pad_config;
    logic                  r_boot_locked;

    logic                  r_in_valid;
    logic [CMD_W-1:0]      r_cmd;
    logic [BUS_ADDR_W-1:0] r_bus_address;
    logic [DATA_W-1:0]     r_write_data;

    logic                  r_out_valid;
    logic [ROM_ADDR_W-1:0] r_rom_address;
    logic                  r_open_bus;

    logic                  has_result;
    logic                  out_free;
    logic                  advance;
    logic                  in_take;
    t_map_view             view;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic                  open_bus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_addr_mask <= ROM_MASK_RESET;
            r_pad_config    <= '0;
            r_boot_locked   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_ROM_ADDR_MASK: r_rom_addr_mask <= i_cfg_wdata[ROM_ADDR_W-1:0];
                CFG_PAD_CONFIG:    r_pad_config    <= i_cfg_wdata[PAD_W-1:0];
                CFG_BOOT_LOCKED:   r_boot_locked   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign has_result = (r_cmd == CMD_ROM_READ) && !r_bus_address[15];
    assign out_free   = !r_out_valid || i_out_ready;
    // a word with no result never waits on the output side
    assign advance    = r_in_valid && (out_free || !has_result);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd         <= i_cmd;
            r_bus_address <= i_bus_address;
            r_write_data  <= i_write_data;
        end
    end

    crmu_state u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_cmd         (r_cmd),
        .i_bus_address (r_bus_address),
        .i_write_data  (r_write_data),
        .i_boot_locked (r_boot_locked),
        .o_view        (view)
    );

    crmu_addr u_addr (
        .i_bus_address   (r_bus_address),
        .i_view          (view),
        .i_rom_addr_mask (r_rom_addr_mask),
        .i_pad_config    (r_pad_config),
        .o_rom_address   (rom_address),
        .o_open_bus      (open_bus)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_rom_address <= rom_address;
            r_open_bus    <= open_bus;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_rom_address = r_rom_address;
    assign o_open_bus    = r_open_bus;

endmodule
